### sv/adte_pkg.sv
// shared types, codes and defaults for the advertising-data element editor
// no dependencies
package adte_pkg;

  localparam int BUF_BYTES_DEF = 32;
  localparam int MAX_VALUE_DEF = 29;

  localparam logic [2:0] CMD_CLEAR    = 3'd0;
  localparam logic [2:0] CMD_LOAD     = 3'd1;
  localparam logic [2:0] CMD_STAGE    = 3'd2;
  localparam logic [2:0] CMD_SET_ELEM = 3'd3;
  localparam logic [2:0] CMD_SET_NAME = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_COMPLETE = 2'd1;
  localparam logic [1:0] CFG_SHORT    = 2'd2;

  localparam logic [5:0] CAPACITY_RST = 6'd31;
  localparam logic [7:0] COMPLETE_RST = 8'd9;
  localparam logic [7:0] SHORT_RST    = 8'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] ad_type;
    logic [4:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic [5:0] buf_len;
    logic       name_shortened;
  } out_t;

  typedef struct packed {
    logic [5:0] buffer_capacity;
    logic [7:0] complete_name_type;
    logic [7:0] short_name_type;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHK_RD,
    S_CHK_LEN,
    S_CHK_TYP,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_NAME_FIT,
    S_HDR_LEN,
    S_HDR_TYP,
    S_CP_RD,
    S_CP_WR,
    S_FIN
  } state_t;

endpackage

### sv/adte_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module adte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/adte_seq.sv
// editing sequencer: handshakes, chain walk, shift, append and copy steps
// depends on adte_pkg; drives the buffer and staging rams
module adte_seq #(
  parameter int BUF_BYTES = adte_pkg::BUF_BYTES_DEF,
  parameter int MAX_VALUE = adte_pkg::MAX_VALUE_DEF,
  localparam int AW  = $clog2(BUF_BYTES),
  localparam int VAW = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  adte_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  adte_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output adte_pkg::out_t     out_data,
  output logic               ad_we,
  output logic [AW-1:0]      ad_waddr,
  output logic [7:0]         ad_wdata,
  output logic [AW-1:0]      ad_raddr,
  input  logic [7:0]         ad_rdata,
  output logic               val_we,
  output logic [VAW-1:0]     val_waddr,
  output logic [7:0]         val_wdata,
  output logic [VAW-1:0]     val_raddr,
  input  logic [7:0]         val_rdata
);

  localparam int LW  = $clog2(BUF_BYTES + 1);
  localparam int VW  = $clog2(MAX_VALUE + 1);
  localparam int MW  = (LW > VW) ? LW : VW;
  localparam int MW8 = (MW > 8) ? MW : 8;
  localparam int CW  = MW8 + 2;

  adte_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] used_r, used_nxt;
  logic [VW-1:0] vcnt_r, vcnt_nxt;
  logic          vovf_r, vovf_nxt;
  logic          name_r, name_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          f1_r, f1_nxt;
  logic [LW-1:0] f1pos_r, f1pos_nxt;
  logic [7:0]    f1len_r, f1len_nxt;
  logic          f2_r, f2_nxt;
  logic [LW-1:0] f2pos_r, f2pos_nxt;
  logic [7:0]    f2len_r, f2len_nxt;
  logic [7:0]    sellen_r, sellen_nxt;
  logic [LW-1:0] src_r, src_nxt;
  logic [LW-1:0] dst_r, dst_nxt;
  logic [VW-1:0] j_r, j_nxt;
  logic [VW-1:0] n_r, n_nxt;
  logic [7:0]    app_r, app_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          short_r, short_nxt;
  logic          out_valid_r, out_valid_nxt;
  adte_pkg::out_t out_data_r, out_data_nxt;

  logic           accept;
  logic           res_we;
  adte_pkg::out_t res;
  logic [CW-1:0]  capc;
  logic [CW-1:0]  avail;
  logic [7:0]     t1;
  logic           chk_bad;
  logic           sel_f;
  logic [LW-1:0]  sel_pos;
  logic [7:0]     sel_len;

  assign in_ready  = (state_r == adte_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign capc = (CW'(cfg.buffer_capacity) > CW'(BUF_BYTES)) ? CW'(BUF_BYTES)
                                                          : CW'(cfg.buffer_capacity);
  assign avail   = capc - CW'(used_r);
  assign t1      = name_r ? cfg.complete_name_type : type_r;
  assign chk_bad = (ad_rdata == 8'd0) ||
                   (CW'(ad_rdata) > (CW'(used_r) - CW'(pos_r) - CW'(1)));
  assign sel_f   = f1_r || (name_r && f2_r);
  assign sel_pos = f1_r ? f1pos_r : f2pos_r;
  assign sel_len = f1_r ? f1len_r : f2len_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adte_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == adte_pkg::CMD_SET_ELEM ||
              in_data.cmd == adte_pkg::CMD_SET_NAME) begin
            if (vovf_r || CW'(used_r) > capc) begin
              state_nxt = adte_pkg::S_FIN;
            end else begin
              state_nxt = adte_pkg::S_CHK_RD;
            end
          end else if (in_data.cmd == adte_pkg::CMD_READ &&
                       CW'(in_data.read_index) < CW'(used_r) &&
                       CW'(in_data.read_index) < CW'(BUF_BYTES)) begin
            state_nxt = adte_pkg::S_READ;
          end
        end
      end
      adte_pkg::S_READ: state_nxt = adte_pkg::S_IDLE;
      adte_pkg::S_CHK_RD: begin
        state_nxt = (pos_r >= used_r) ? adte_pkg::S_DECIDE : adte_pkg::S_CHK_LEN;
      end
      adte_pkg::S_CHK_LEN: begin
        state_nxt = chk_bad ? adte_pkg::S_FIN : adte_pkg::S_CHK_TYP;
      end
      adte_pkg::S_CHK_TYP: state_nxt = adte_pkg::S_CHK_RD;
      adte_pkg::S_DECIDE: begin
        if (name_r) begin
          state_nxt = sel_f ? adte_pkg::S_SH_RD : adte_pkg::S_NAME_FIT;
        end else if (f1_r && CW'(f1len_r) == CW'(vcnt_r) + CW'(1)) begin
          state_nxt = adte_pkg::S_CP_RD;
        end else if (f1_r) begin
          if (CW'(used_r) - CW'(f1len_r) - CW'(1) + CW'(vcnt_r) + CW'(2) > capc) begin
            state_nxt = adte_pkg::S_FIN;
          end else begin
            state_nxt = adte_pkg::S_SH_RD;
          end
        end else if (CW'(used_r) + CW'(vcnt_r) + CW'(2) > capc) begin
          state_nxt = adte_pkg::S_FIN;
        end else begin
          state_nxt = adte_pkg::S_HDR_LEN;
        end
      end
      adte_pkg::S_SH_RD: begin
        if (src_r >= used_r) begin
          state_nxt = name_r ? adte_pkg::S_NAME_FIT : adte_pkg::S_HDR_LEN;
        end else begin
          state_nxt = adte_pkg::S_SH_WR;
        end
      end
      adte_pkg::S_SH_WR: state_nxt = adte_pkg::S_SH_RD;
      adte_pkg::S_NAME_FIT: begin
        state_nxt = (avail < CW'(2)) ? adte_pkg::S_FIN : adte_pkg::S_HDR_LEN;
      end
      adte_pkg::S_HDR_LEN: state_nxt = adte_pkg::S_HDR_TYP;
      adte_pkg::S_HDR_TYP: state_nxt = adte_pkg::S_CP_RD;
      adte_pkg::S_CP_RD: begin
        state_nxt = (j_r >= n_r) ? adte_pkg::S_FIN : adte_pkg::S_CP_WR;
      end
      adte_pkg::S_CP_WR: state_nxt = adte_pkg::S_CP_RD;
      adte_pkg::S_FIN: state_nxt = adte_pkg::S_IDLE;
      default: state_nxt = adte_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    used_nxt   = used_r;
    vcnt_nxt   = vcnt_r;
    vovf_nxt   = vovf_r;
    name_nxt   = name_r;
    type_nxt   = type_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    f1_nxt     = f1_r;
    f1pos_nxt  = f1pos_r;
    f1len_nxt  = f1len_r;
    f2_nxt     = f2_r;
    f2pos_nxt  = f2pos_r;
    f2len_nxt  = f2len_r;
    sellen_nxt = sellen_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    app_nxt    = app_r;
    status_nxt = status_r;
    short_nxt  = short_r;
    ad_we      = 1'b0;
    ad_waddr   = '0;
    ad_wdata   = '0;
    ad_raddr   = '0;
    val_we     = 1'b0;
    val_waddr  = '0;
    val_wdata  = '0;
    val_raddr  = '0;
    res_we     = 1'b0;
    res        = '0;
    case (state_r)
      adte_pkg::S_IDLE: begin
        if (accept) begin
          res_we = 1'b1;
          case (in_data.cmd)
            adte_pkg::CMD_CLEAR: begin
              used_nxt = '0;
              vcnt_nxt = '0;
              vovf_nxt = 1'b0;
            end
            adte_pkg::CMD_LOAD: begin
              if (CW'(used_r) < CW'(BUF_BYTES)) begin
                ad_we    = 1'b1;
                ad_waddr = AW'(used_r);
                ad_wdata = in_data.data_byte;
                used_nxt = LW'(CW'(used_r) + CW'(1));
              end else begin
                res.status = adte_pkg::ST_FULL;
              end
            end
            adte_pkg::CMD_STAGE: begin
              if (CW'(vcnt_r) < CW'(MAX_VALUE)) begin
                val_we    = 1'b1;
                val_waddr = VAW'(vcnt_r);
                val_wdata = in_data.data_byte;
                vcnt_nxt  = VW'(CW'(vcnt_r) + CW'(1));
              end else begin
                vovf_nxt   = 1'b1;
                res.status = adte_pkg::ST_FULL;
              end
            end
            adte_pkg::CMD_SET_ELEM, adte_pkg::CMD_SET_NAME: begin
              res_we     = 1'b0;
              name_nxt   = (in_data.cmd == adte_pkg::CMD_SET_NAME);
              type_nxt   = in_data.ad_type;
              status_nxt = adte_pkg::ST_REJECT;
              short_nxt  = 1'b0;
              pos_nxt    = '0;
              f1_nxt     = 1'b0;
              f2_nxt     = 1'b0;
            end
            adte_pkg::CMD_READ: begin
              if (CW'(in_data.read_index) < CW'(used_r) &&
                  CW'(in_data.read_index) < CW'(BUF_BYTES)) begin
                res_we   = 1'b0;
                ad_raddr = AW'(in_data.read_index);
              end
            end
            default: ;
          endcase
          res.buf_len = 6'(used_nxt);
        end
      end
      adte_pkg::S_READ: begin
        res_we        = 1'b1;
        res.read_byte = ad_rdata;
        res.buf_len   = 6'(used_r);
      end
      adte_pkg::S_CHK_RD: begin
        ad_raddr = AW'(pos_r);
      end
      adte_pkg::S_CHK_LEN: begin
        len_nxt  = ad_rdata;
        ad_raddr = AW'(CW'(pos_r) + CW'(1));
      end
      adte_pkg::S_CHK_TYP: begin
        if (!f1_r && ad_rdata == t1) begin
          f1_nxt    = 1'b1;
          f1pos_nxt = pos_r;
          f1len_nxt = len_r;
        end
        if (name_r && !f2_r && ad_rdata == cfg.short_name_type) begin
          f2_nxt    = 1'b1;
          f2pos_nxt = pos_r;
          f2len_nxt = len_r;
        end
        pos_nxt = LW'(CW'(pos_r) + CW'(len_r) + CW'(1));
      end
      adte_pkg::S_DECIDE: begin
        n_nxt      = vcnt_r;
        j_nxt      = '0;
        app_nxt    = type_r;
        sellen_nxt = sel_len;
        src_nxt    = LW'(CW'(sel_pos) + CW'(sel_len) + CW'(1));
        dst_nxt    = sel_pos;
        status_nxt = adte_pkg::ST_OK;
        if (!name_r) begin
          if (f1_r && CW'(f1len_r) == CW'(vcnt_r) + CW'(1)) begin
            dst_nxt = LW'(CW'(f1pos_r) + CW'(2));
          end else if (f1_r) begin
            if (CW'(used_r) - CW'(f1len_r) - CW'(1) + CW'(vcnt_r) + CW'(2) > capc) begin
              status_nxt = adte_pkg::ST_REJECT;
            end
          end else if (CW'(used_r) + CW'(vcnt_r) + CW'(2) > capc) begin
            status_nxt = adte_pkg::ST_REJECT;
          end
        end
      end
      adte_pkg::S_SH_RD: begin
        if (src_r >= used_r) begin
          used_nxt = LW'(CW'(used_r) - CW'(sellen_r) - CW'(1));
        end else begin
          ad_raddr = AW'(src_r);
        end
      end
      adte_pkg::S_SH_WR: begin
        ad_we    = 1'b1;
        ad_waddr = AW'(dst_r);
        ad_wdata = ad_rdata;
        src_nxt  = LW'(CW'(src_r) + CW'(1));
        dst_nxt  = LW'(CW'(dst_r) + CW'(1));
      end
      adte_pkg::S_NAME_FIT: begin
        app_nxt = cfg.complete_name_type;
        if (avail < CW'(2)) begin
          status_nxt = adte_pkg::ST_REJECT;
        end else if (CW'(n_r) + CW'(2) > avail) begin
          n_nxt     = VW'(avail - CW'(2));
          app_nxt   = cfg.short_name_type;
          short_nxt = 1'b1;
        end
      end
      adte_pkg::S_HDR_LEN: begin
        ad_we    = 1'b1;
        ad_waddr = AW'(used_r);
        ad_wdata = 8'(CW'(n_r) + CW'(1));
      end
      adte_pkg::S_HDR_TYP: begin
        ad_we    = 1'b1;
        ad_waddr = AW'(CW'(used_r) + CW'(1));
        ad_wdata = app_r;
        dst_nxt  = LW'(CW'(used_r) + CW'(2));
        used_nxt = LW'(CW'(used_r) + CW'(n_r) + CW'(2));
        j_nxt    = '0;
      end
      adte_pkg::S_CP_RD: begin
        val_raddr = VAW'(j_r);
      end
      adte_pkg::S_CP_WR: begin
        ad_we    = 1'b1;
        ad_waddr = AW'(dst_r);
        ad_wdata = val_rdata;
        j_nxt    = VW'(CW'(j_r) + CW'(1));
        dst_nxt  = LW'(CW'(dst_r) + CW'(1));
      end
      adte_pkg::S_FIN: begin
        res_we             = 1'b1;
        res.status         = status_r;
        res.buf_len        = 6'(used_r);
        res.name_shortened = short_r && (status_r == adte_pkg::ST_OK);
        vcnt_nxt           = '0;
        vovf_nxt           = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (res_we) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adte_pkg::S_IDLE;
      used_r      <= '0;
      vcnt_r      <= '0;
      vovf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      vcnt_r      <= vcnt_nxt;
      vovf_r      <= vovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    name_r     <= name_nxt;
    type_r     <= type_nxt;
    pos_r      <= pos_nxt;
    len_r      <= len_nxt;
    f1_r       <= f1_nxt;
    f1pos_r    <= f1pos_nxt;
    f1len_r    <= f1len_nxt;
    f2_r       <= f2_nxt;
    f2pos_r    <= f2pos_nxt;
    f2len_r    <= f2len_nxt;
    sellen_r   <= sellen_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    app_r      <= app_nxt;
    status_r   <= status_nxt;
    short_r    <= short_nxt;
    out_data_r <= out_data_nxt;
  end

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == adte_pkg::S_FIN |-> !out_valid_r)
    else $error("edit result with output slot occupied");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(used_r) <= CW'(BUF_BYTES))
    else $error("used length beyond buffer");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(vcnt_r) <= CW'(MAX_VALUE))
    else $error("staged count beyond staging store");

  a_edit_consumes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == adte_pkg::S_FIN |=> vcnt_r == '0 && !vovf_r)
    else $error("staged value not consumed by edit");

endmodule

### sv/adv_data_tlv_editor_top.sv
// top level of the advertising-data element editor: config registers, rams, sequencer
// depends on adte_pkg, adte_ram, adte_seq
// Clear, load, stage and unused commands finish when accepted; a read of a valid index
// also passes through a read state. An edit runs decide and result steps plus, per
// element of the chain check, a read, a length and a type step; a read and a write per
// byte moved when an old element is removed; a length and a type write for the new
// header; and a read and a write per value byte copied. An early reject goes straight
// to the result step. Bytes move one at a time, set by the single registered read port.
// Results leave through an output register; a new beat is taken once the previous
// item is done and its result slot is free or draining.
module adv_data_tlv_editor_top #(
  parameter int BUF_BYTES = adte_pkg::BUF_BYTES_DEF,
  parameter int MAX_VALUE = adte_pkg::MAX_VALUE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  adte_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output adte_pkg::out_t out_data
);

  localparam int AW  = $clog2(BUF_BYTES);
  localparam int VAW = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;

  adte_pkg::cfg_t cfg_r, cfg_nxt;

  logic           ad_we;
  logic [AW-1:0]  ad_waddr;
  logic [7:0]     ad_wdata;
  logic [AW-1:0]  ad_raddr;
  logic [7:0]     ad_rdata;
  logic           val_we;
  logic [VAW-1:0] val_waddr;
  logic [7:0]     val_wdata;
  logic [VAW-1:0] val_raddr;
  logic [7:0]     val_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        adte_pkg::CFG_CAPACITY: cfg_nxt.buffer_capacity    = cfg_data[5:0];
        adte_pkg::CFG_COMPLETE: cfg_nxt.complete_name_type = cfg_data;
        adte_pkg::CFG_SHORT:    cfg_nxt.short_name_type    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_capacity    <= adte_pkg::CAPACITY_RST;
      cfg_r.complete_name_type <= adte_pkg::COMPLETE_RST;
      cfg_r.short_name_type    <= adte_pkg::SHORT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  adte_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ad_ram (
    .clk   (clk),
    .we    (ad_we),
    .waddr (ad_waddr),
    .wdata (ad_wdata),
    .raddr (ad_raddr),
    .rdata (ad_rdata)
  );

  adte_ram #(.WIDTH(8), .DEPTH(MAX_VALUE)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  adte_seq #(.BUF_BYTES(BUF_BYTES), .MAX_VALUE(MAX_VALUE)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ad_we     (ad_we),
    .ad_waddr  (ad_waddr),
    .ad_wdata  (ad_wdata),
    .ad_raddr  (ad_raddr),
    .ad_rdata  (ad_rdata),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .val_raddr (val_raddr),
    .val_rdata (val_rdata)
  );

endmodule
